FILE: hw/rtl/qrs_pkg.sv
// Shared types and constants of the quadratic root solver.
`default_nettype none
package qrs_pkg;

	localparam int TOL_W          = 16;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int WORD_WIDTH_DEF = 32;
	localparam logic [TOL_W-1:0] ZERO_TOL_RESET = 16'd66;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_ONE  = 2'd1,
		KIND_TWO  = 2'd2,
		KIND_INF  = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic  use1;
		logic  use2;
		logic  two;
	} ctl_t;

	localparam int CTL_W = $bits(ctl_t);

endpackage
`default_nettype wire

FILE: hw/rtl/qrs_front.sv
// Front stages: decode, products, discriminant and case selection.
`default_nettype none
module qrs_front #(
	parameter int WORD_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic [qrs_pkg::TOL_W-1:0]     tol,
	input  wire logic                          valid_i,
	input  wire logic [WORD_WIDTH-1:0]         coef_a,
	input  wire logic [WORD_WIDTH-1:0]         coef_b,
	input  wire logic [WORD_WIDTH-1:0]         coef_c,
	output logic                               valid_o,
	output logic [2*WORD_WIDTH+1:0]            d_o,
	output qrs_pkg::ctl_t                      ctl_o,
	output logic                               na_o,
	output logic [WORD_WIDTH:0]                bv_o,
	output logic [WORD_WIDTH+FRAC_BITS+1:0]    num1_o,
	output logic [WORD_WIDTH:0]                den1_o,
	output logic                               neg1_o,
	output logic [WORD_WIDTH+FRAC_BITS+1:0]    num2_o,
	output logic [WORD_WIDTH:0]                den2_o,
	output logic                               neg2_o
);
	import qrs_pkg::*;

	localparam int W  = WORD_WIDTH;
	localparam int DW = 2*W+2;
	localparam int NW = W+2+FRAC_BITS;

	logic [W-1:0]   tolw;
	logic [W-1:0]   ma_c, mb_c, mc_c;
	logic           v_s1, na_s1, nb_s1, nc_s1, za_s1, zb_s1, zc_s1;
	logic [W-1:0]   ma_s1, mb_s1, mc_s1;
	logic           v_s2, na_s2, nb_s2, nc_s2, za_s2, zb_s2, zc_s2;
	logic [W-1:0]   ma_s2, mb_s2, mc_s2;
	logic [2*W-1:0] bb_s2, ac_s2;
	logic [DW-1:0]  bbx, ac4, d_c, tol_d;
	logic           dneg, dsmall;
	ctl_t           ctl_c;
	logic [NW-1:0]  num1_c;
	logic [W:0]     den1_c, den2_c;
	logic           neg1_c;

	assign tolw = W'(tol);
	assign ma_c = coef_a[W-1] ? -coef_a : coef_a;
	assign mb_c = coef_b[W-1] ? -coef_b : coef_b;
	assign mc_c = coef_c[W-1] ? -coef_c : coef_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			valid_o <= 1'b0;
		end else if (en) begin
			v_s1 <= valid_i;
			v_s2 <= v_s1;
			valid_o <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ma_s1 <= ma_c;
			mb_s1 <= mb_c;
			mc_s1 <= mc_c;
			na_s1 <= coef_a[W-1];
			nb_s1 <= coef_b[W-1];
			nc_s1 <= coef_c[W-1];
			za_s1 <= (ma_c == '0) || (ma_c < tolw);
			zb_s1 <= (mb_c == '0) || (mb_c < tolw);
			zc_s1 <= (mc_c == '0) || (mc_c < tolw);
			bb_s2 <= mb_s1 * mb_s1;
			ac_s2 <= ma_s1 * mc_s1;
			ma_s2 <= ma_s1;
			mb_s2 <= mb_s1;
			mc_s2 <= mc_s1;
			na_s2 <= na_s1;
			nb_s2 <= nb_s1;
			nc_s2 <= nc_s1;
			za_s2 <= za_s1;
			zb_s2 <= zb_s1;
			zc_s2 <= zc_s1;
		end
	end

	assign bbx    = {2'b00, bb_s2};
	assign ac4    = {ac_s2, 2'b00};
	assign dneg   = (na_s2 == nc_s2) && (bbx < ac4);
	assign d_c    = (na_s2 != nc_s2) ? bbx + ac4 : (dneg ? ac4 - bbx : bbx - ac4);
	assign tol_d  = DW'(tol) << FRAC_BITS;
	assign dsmall = d_c < tol_d;

	always_comb begin
		ctl_c  = '{kind: KIND_NONE, use1: 1'b0, use2: 1'b0, two: 1'b0};
		num1_c = NW'(mb_s2) << FRAC_BITS;
		den1_c = {ma_s2, 1'b0};
		neg1_c = ~(nb_s2 ^ na_s2);
		den2_c = {1'b0, ma_s2};
		if (za_s2) begin
			if (zb_s2) begin
				ctl_c.kind = zc_s2 ? KIND_INF : KIND_NONE;
			end else begin
				ctl_c.kind = KIND_ONE;
				ctl_c.use1 = 1'b1;
				num1_c     = NW'(mc_s2) << FRAC_BITS;
				den1_c     = {1'b0, mb_s2};
				neg1_c     = ~(nc_s2 ^ nb_s2);
			end
		end else if (zc_s2) begin
			ctl_c.kind = KIND_TWO;
			ctl_c.use2 = 1'b1;
		end else if (dneg) begin
			ctl_c.kind = KIND_NONE;
		end else if (dsmall) begin
			ctl_c.kind = KIND_ONE;
			ctl_c.use1 = 1'b1;
		end else begin
			ctl_c.kind = KIND_TWO;
			ctl_c.use1 = 1'b1;
			ctl_c.use2 = 1'b1;
			ctl_c.two  = 1'b1;
			den2_c     = {ma_s2, 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_o    <= d_c;
			na_o   <= na_s2;
			bv_o   <= nb_s2 ? -{1'b0, mb_s2} : {1'b0, mb_s2};
			num1_o <= num1_c;
			den1_o <= den1_c;
			neg1_o <= neg1_c;
			num2_o <= NW'(mb_s2) << FRAC_BITS;
			den2_o <= den2_c;
			neg2_o <= ~(nb_s2 ^ na_s2);
			ctl_o  <= ctl_c;
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/qrs_sqrt_cell.sv
// One root bit of the square root chain.
`default_nettype none
module qrs_sqrt_cell #(
	parameter int DW  = 66,
	parameter int RW  = 33,
	parameter int PW  = 8,
	parameter int IDX = 0
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          valid_i,
	input  wire logic [DW-1:0] rem_i,
	input  wire logic [RW-1:0] root_i,
	input  wire logic [PW-1:0] pass_i,
	output logic               valid_o,
	output logic [DW-1:0]      rem_o,
	output logic [RW-1:0]      root_o,
	output logic [PW-1:0]      pass_o
);
	logic [DW-1:0] trial;
	logic          fits;

	assign trial = (DW'(root_i) << (IDX+1)) | (DW'(1) << (2*IDX));
	assign fits  = rem_i >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else if (en) begin
			valid_o <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o  <= fits ? rem_i - trial : rem_i;
			root_o <= fits ? (root_i | (RW'(1) << IDX)) : root_i;
			pass_o <= pass_i;
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/qrs_div_cell.sv
// One quotient bit of a restoring divider chain.
`default_nettype none
module qrs_div_cell #(
	parameter int NW  = 50,
	parameter int DNW = 33,
	parameter int PW  = 1
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           valid_i,
	input  wire logic [NW-1:0]  num_i,
	input  wire logic [DNW-1:0] den_i,
	input  wire logic [DNW-1:0] rem_i,
	input  wire logic [NW-1:0]  quo_i,
	input  wire logic [PW-1:0]  pass_i,
	output logic                valid_o,
	output logic [NW-1:0]       num_o,
	output logic [DNW-1:0]      den_o,
	output logic [DNW-1:0]      rem_o,
	output logic [NW-1:0]       quo_o,
	output logic [PW-1:0]       pass_o
);
	logic [DNW:0] part;
	logic [DNW:0] diff;
	logic         ge;

	assign part = {rem_i, num_i[NW-1]};
	assign diff = part - {1'b0, den_i};
	assign ge   = part >= {1'b0, den_i};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else if (en) begin
			valid_o <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_o  <= num_i << 1;
			den_o  <= den_i;
			rem_o  <= ge ? diff[DNW-1:0] : part[DNW-1:0];
			quo_o  <= {quo_i[NW-2:0], ge};
			pass_o <= pass_i;
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/quadratic_root_solver_top.sv
// Top level of the quadratic root solver: cell chains, saturation and output register.
//
// Requests carry coefficients a, b and c (signed fixed point) on the s_axis channel;
// one result per request leaves on m_axis: root_first, root_second and overflow in
// tdata, root_kind in tuser. cfg_we writes the zero tolerance from cfg_wdata; write it
// only while no request is in flight.
// A request is taken every cycle while the chain is not frozen. A result passes through
// three front stages, one cell per root bit of the square root (WORD_WIDTH+1), one
// stage forming the numerators, one cell per quotient bit of the two dividers
// (WORD_WIDTH+FRAC_BITS+2) and the output register.
// If the receiver stalls with a result held and another at the divider ends, the whole
// chain freezes; an empty slot there lets the chain advance and new requests enter.
// Reset clears all valid flags and sets the tolerance to 66; no clearing pass.
`default_nettype none
module quadratic_root_solver_top #(
	parameter int WORD_WIDTH = qrs_pkg::WORD_WIDTH_DEF,
	parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [qrs_pkg::TOL_W-1:0]             cfg_wdata,
	input  wire logic                                  s_axis_tvalid,
	output logic                                       s_axis_tready,
	// coef_a, coef_b, coef_c, zero padding
	input  wire logic [((3*WORD_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
	output logic                                       m_axis_tvalid,
	input  wire logic                                  m_axis_tready,
	// root_first, root_second, overflow, zero padding
	output logic [((2*WORD_WIDTH+8)/8)*8-1:0]          m_axis_tdata,
	// root_kind
	output logic [1:0]                                 m_axis_tuser
);
	import qrs_pkg::*;

	localparam int W     = WORD_WIDTH;
	localparam int DW    = 2*W+2;
	localparam int RW    = W+1;
	localparam int NW    = W+2+FRAC_BITS;
	localparam int DNW   = W+1;
	localparam int OUT_W = ((2*W+8)/8)*8;
	localparam int PW    = CTL_W + 1 + (W+1) + 2*(NW+DNW+1);
	localparam int P1W   = CTL_W + 1;

	logic [TOL_W-1:0] tol_q;
	logic             en;

	logic             f_valid;
	logic [DW-1:0]    f_d;
	ctl_t             f_ctl;
	logic             f_na, f_neg1, f_neg2;
	logic [W:0]       f_bv;
	logic [NW-1:0]    f_num1, f_num2;
	logic [DNW-1:0]   f_den1, f_den2;

	logic             sq_v    [0:RW];
	logic [DW-1:0]    sq_rem  [0:RW];
	logic [RW-1:0]    sq_root [0:RW];
	logic [PW-1:0]    sq_pass [0:RW];

	ctl_t             m_ctl;
	logic             m_na, m_neg1, m_neg2;
	logic [W:0]       m_bv;
	logic [NW-1:0]    m_num1, m_num2;
	logic [DNW-1:0]   m_den1, m_den2;
	logic signed [W+2:0] t1, t2;
	logic [W+2:0]     a1, a2;

	logic             v_s4;
	ctl_t             ctl_s4;
	logic             neg1_s4, neg2_s4;
	logic [NW-1:0]    num1_s4, num2_s4;
	logic [DNW-1:0]   den1_s4, den2_s4;

	logic             d1_v   [0:NW];
	logic [NW-1:0]    d1_num [0:NW];
	logic [DNW-1:0]   d1_den [0:NW];
	logic [DNW-1:0]   d1_rem [0:NW];
	logic [NW-1:0]    d1_quo [0:NW];
	logic [P1W-1:0]   d1_pass[0:NW];
	logic             d2_v   [0:NW];
	logic [NW-1:0]    d2_num [0:NW];
	logic [DNW-1:0]   d2_den [0:NW];
	logic [DNW-1:0]   d2_rem [0:NW];
	logic [NW-1:0]    d2_quo [0:NW];
	logic             d2_pass[0:NW];

	ctl_t             e_ctl;
	logic             e_neg1, e_neg2;
	logic [NW-1:0]    maxneg, maxpos;
	logic             ov1, ov2;
	logic [NW-1:0]    mag1, mag2, nmag1, nmag2;
	logic [W-1:0]     r1_c, r2_c;
	logic             v_last;

	logic             out_valid_q;
	kind_t            kind_q;
	logic [W-1:0]     root1_q, root2_q;
	logic             ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= ZERO_TOL_RESET;
		end else if (cfg_we) begin
			tol_q <= cfg_wdata;
		end
	end

	assign v_last        = d1_v[NW];
	assign en            = m_axis_tready | ~out_valid_q | ~v_last;
	assign s_axis_tready = en;

	qrs_front #(.WORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .tol(tol_q),
		.valid_i(s_axis_tvalid),
		.coef_a(s_axis_tdata[W-1:0]),
		.coef_b(s_axis_tdata[2*W-1:W]),
		.coef_c(s_axis_tdata[3*W-1:2*W]),
		.valid_o(f_valid), .d_o(f_d), .ctl_o(f_ctl), .na_o(f_na), .bv_o(f_bv),
		.num1_o(f_num1), .den1_o(f_den1), .neg1_o(f_neg1),
		.num2_o(f_num2), .den2_o(f_den2), .neg2_o(f_neg2)
	);

	assign sq_v[0]    = f_valid;
	assign sq_rem[0]  = f_d;
	assign sq_root[0] = '0;
	assign sq_pass[0] = {f_ctl, f_na, f_bv, f_num1, f_den1, f_neg1, f_num2, f_den2, f_neg2};

	for (genvar k = 0; k < RW; k++) begin : g_sqrt
		qrs_sqrt_cell #(.DW(DW), .RW(RW), .PW(PW), .IDX(RW-1-k)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.valid_i(sq_v[k]), .rem_i(sq_rem[k]), .root_i(sq_root[k]), .pass_i(sq_pass[k]),
			.valid_o(sq_v[k+1]), .rem_o(sq_rem[k+1]), .root_o(sq_root[k+1]),
			.pass_o(sq_pass[k+1])
		);
	end

	assign {m_ctl, m_na, m_bv, m_num1, m_den1, m_neg1, m_num2, m_den2, m_neg2} = sq_pass[RW];

	assign t1 = $signed({{2{m_bv[W]}}, m_bv}) + $signed({2'b00, sq_root[RW]});
	assign t2 = $signed({{2{m_bv[W]}}, m_bv}) - $signed({2'b00, sq_root[RW]});
	assign a1 = t1[W+2] ? -t1 : t1;
	assign a2 = t2[W+2] ? -t2 : t2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= sq_v[RW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s4  <= m_ctl;
			den1_s4 <= m_den1;
			den2_s4 <= m_den2;
			if (m_ctl.two) begin
				num1_s4 <= NW'(a1[W+1:0]) << FRAC_BITS;
				num2_s4 <= NW'(a2[W+1:0]) << FRAC_BITS;
				neg1_s4 <= (~t1[W+2] & (t1 != '0)) ^ m_na;
				neg2_s4 <= (~t2[W+2] & (t2 != '0)) ^ m_na;
			end else begin
				num1_s4 <= m_num1;
				num2_s4 <= m_num2;
				neg1_s4 <= m_neg1;
				neg2_s4 <= m_neg2;
			end
		end
	end

	assign d1_v[0]    = v_s4;
	assign d1_num[0]  = num1_s4;
	assign d1_den[0]  = den1_s4;
	assign d1_rem[0]  = '0;
	assign d1_quo[0]  = '0;
	assign d1_pass[0] = {ctl_s4, neg1_s4};
	assign d2_v[0]    = v_s4;
	assign d2_num[0]  = num2_s4;
	assign d2_den[0]  = den2_s4;
	assign d2_rem[0]  = '0;
	assign d2_quo[0]  = '0;
	assign d2_pass[0] = neg2_s4;

	for (genvar k = 0; k < NW; k++) begin : g_div
		qrs_div_cell #(.NW(NW), .DNW(DNW), .PW(P1W)) u_first (
			.clk(clk), .arst_n(arst_n), .en(en),
			.valid_i(d1_v[k]), .num_i(d1_num[k]), .den_i(d1_den[k]),
			.rem_i(d1_rem[k]), .quo_i(d1_quo[k]), .pass_i(d1_pass[k]),
			.valid_o(d1_v[k+1]), .num_o(d1_num[k+1]), .den_o(d1_den[k+1]),
			.rem_o(d1_rem[k+1]), .quo_o(d1_quo[k+1]), .pass_o(d1_pass[k+1])
		);
		qrs_div_cell #(.NW(NW), .DNW(DNW), .PW(1)) u_second (
			.clk(clk), .arst_n(arst_n), .en(en),
			.valid_i(d2_v[k]), .num_i(d2_num[k]), .den_i(d2_den[k]),
			.rem_i(d2_rem[k]), .quo_i(d2_quo[k]), .pass_i(d2_pass[k]),
			.valid_o(d2_v[k+1]), .num_o(d2_num[k+1]), .den_o(d2_den[k+1]),
			.rem_o(d2_rem[k+1]), .quo_o(d2_quo[k+1]), .pass_o(d2_pass[k+1])
		);
	end

	assign {e_ctl, e_neg1} = d1_pass[NW];
	assign e_neg2          = d2_pass[NW];

	assign maxneg = NW'(1) << (W-1);
	assign maxpos = maxneg - NW'(1);
	assign ov1    = e_neg1 ? (d1_quo[NW] > maxneg) : (d1_quo[NW] > maxpos);
	assign ov2    = e_neg2 ? (d2_quo[NW] > maxneg) : (d2_quo[NW] > maxpos);
	assign mag1   = ov1 ? (e_neg1 ? maxneg : maxpos) : d1_quo[NW];
	assign mag2   = ov2 ? (e_neg2 ? maxneg : maxpos) : d2_quo[NW];
	assign nmag1  = -mag1;
	assign nmag2  = -mag2;
	assign r1_c   = e_neg1 ? nmag1[W-1:0] : mag1[W-1:0];
	assign r2_c   = e_neg2 ? nmag2[W-1:0] : mag2[W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (v_last && en) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (v_last && en) begin
			kind_q  <= e_ctl.kind;
			root1_q <= e_ctl.use1 ? r1_c : '0;
			root2_q <= e_ctl.use2 ? r2_c : '0;
			ovf_q   <= (e_ctl.use1 & ov1) | (e_ctl.use2 & ov2);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_W-2*W-1){1'b0}}, ovf_q, root2_q, root1_q};
	assign m_axis_tuser  = kind_q;

	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		d1_v[NW] == d2_v[NW])
		else $error("divider chains out of step");

	a_no_root_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (kind_q == KIND_NONE || kind_q == KIND_INF)
		|-> (root1_q == '0) && (root2_q == '0) && !ovf_q)
		else $error("roots present without a root kind");

	a_one_root: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (kind_q == KIND_ONE) |-> (root2_q == '0))
		else $error("second root present with one root");

	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_axis_tready && v_last |=> out_valid_q && $stable(root1_q))
		else $error("held result lost under stall");

endmodule
`default_nettype wire
